/* rtl/bms_pkg.sv */
// bms_pkg: shared types, constants and saturating Q-format helpers
// for the Brent minimizer step engine. No dependencies.
package bms_pkg;

    localparam int FRAC_BITS = 48;

    typedef logic signed [63:0] q_t;

    localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

    localparam logic [63:0] GOLD_Q62 = 64'd1761507313596588280;
    localparam q_t GOLD = q_t'((GOLD_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));

    // ceil(2^64 / 3): high word of x * RECIP3 is x / 3 for x below 2^63
    localparam q_t RECIP3 = 64'sh5555_5555_5555_5556;

    localparam logic [62:0] TOL_RESET = 63'd281474976;
    localparam logic [62:0] REL_EPS_RESET = 63'd4194304;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_VALUE = 1'b1;

    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_REL_EPS = 1'b1;

    localparam logic [1:0] ST_EVAL = 2'd0;
    localparam logic [1:0] ST_MINIMUM = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_TRIAL
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_OUT,
        S_ST1,
        S_T0,
        S_A0,
        S_A1,
        S_A2,
        S_A3,
        S_A4,
        S_A5,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_P5,
        S_P6,
        S_P7,
        S_P8,
        S_P9,
        S_P10,
        S_P11,
        S_G0,
        S_G1,
        S_F0,
        S_MUL,
        S_MULF,
        S_DIV,
        S_DIVF
    } seq_state_t;

    function automatic q_t sat_add(q_t a, q_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return q_t'(s[63:0]);
    endfunction

    function automatic q_t sat_sub(q_t a, q_t b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return q_t'(s[63:0]);
    endfunction

    function automatic q_t sat_abs(q_t a);
        if (a == Q_MIN)
        begin
            return Q_MAX;
        end
        return a[63] ? -a : a;
    endfunction

    function automatic q_t sat_neg(q_t a);
        return (a == Q_MIN) ? Q_MAX : -a;
    endfunction

    // divide by two, toward zero
    function automatic q_t half_tz(q_t a);
        logic [64:0] s;
        s = {a[63], a} + {64'd0, a[63]};
        return q_t'(s[64:1]);
    endfunction

    function automatic q_t midpoint(q_t a, q_t b);
        q_t c;
        c = '0;
        if (a[0] && b[0] && (a[63] == b[63]))
        begin
            c = a[63] ? -64'sd1 : 64'sd1;
        end
        return half_tz(a) + half_tz(b) + c;
    endfunction

    function automatic logic [63:0] mag(q_t a);
        logic [63:0] u;
        u = a;
        return a[63] ? (~u + 64'd1) : u;
    endfunction

    function automatic q_t pack(logic neg, logic [63:0] m);
        if (!neg)
        begin
            return m[63] ? Q_MAX : q_t'(m);
        end
        if (m[63])
        begin
            return Q_MIN;
        end
        return q_t'(~m + 64'd1);
    endfunction

endpackage

/* rtl/brent_minimizer_step.sv */
// Brent minimizer step engine: one shared 32x32 multiplier (four passes per
// product) and one radix-2 divider under a sequencer. Depends on bms_pkg.
// A start request runs one golden-section product; an ignored value is answered in
//   the next cycle; a value request runs multiplier products (tolerance/3 by reciprocal
//   product) and, on the parabolic path, may run the divider for the quotient.
// Throughput: one request at a time; in_ready is low from accept until the
//   response is taken.
// Reset: rst_n asynchronous, active low; search goes idle, config registers reload.
module brent_minimizer_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [63:0] lower_end,
    input  logic [63:0] upper_end,
    input  logic [63:0] func_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] point,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int FB = bms_pkg::FRAC_BITS;

    bms_pkg::seq_state_t state_reg, state_next, ret_reg, ret_next;
    bms_pkg::phase_t phase_reg, phase_next;

    logic [62:0] tolerance_reg, rel_eps_reg;

    bms_pkg::q_t lo_reg, lo_next, hi_reg, hi_next, step_reg, step_next;
    bms_pkg::q_t prev_reg, prev_next, bx_reg, bx_next, sx_reg, sx_next;
    bms_pkg::q_t tx_reg, tx_next, bf_reg, bf_next, sf_reg, sf_next;
    bms_pkg::q_t tf_reg, tf_next, trial_reg, trial_next, fu_reg, fu_next;
    bms_pkg::q_t xm_reg, xm_next, t3_reg, t3_next, tol1_reg, tol1_next;
    bms_pkg::q_t tol2_reg, tol2_next, ta_reg, ta_next, tb_reg, tb_next;
    bms_pkg::q_t tc_reg, tc_next, dw_reg, dw_next, dv_reg, dv_next;
    bms_pkg::q_t p_reg, p_next, q_reg, q_next;
    bms_pkg::q_t pt_reg, pt_next;
    logic [1:0] st_reg, st_next;

    logic [63:0] ma_reg, ma_next, mb_reg, mb_next;
    logic mneg_reg, mneg_next;
    logic [127:0] macc_reg, macc_next;
    logic [1:0] mcnt_reg, mcnt_next;
    bms_pkg::q_t mres_reg, mres_next;

    logic [63:0] drem_reg, drem_next, dlo_reg, dlo_next, dquo_reg, dquo_next;
    logic [63:0] dd_reg, dd_next;
    logic dneg_reg, dneg_next;
    logic [5:0] dcnt_reg, dcnt_next;
    bms_pkg::q_t dres_reg, dres_next;

    assign in_ready = (state_reg == bms_pkg::S_IDLE);
    assign out_valid = (state_reg == bms_pkg::S_OUT);
    assign point = pt_reg;
    assign status = st_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= bms_pkg::TOL_RESET;
            rel_eps_reg <= bms_pkg::REL_EPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bms_pkg::REG_TOLERANCE: tolerance_reg <= cfg_data[62:0];
                bms_pkg::REG_REL_EPS:   rel_eps_reg <= cfg_data[62:0];
                default:                tolerance_reg <= tolerance_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bms_pkg::S_IDLE;
            ret_reg <= bms_pkg::S_IDLE;
            phase_reg <= bms_pkg::PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        step_reg <= step_next;
        prev_reg <= prev_next;
        bx_reg <= bx_next;
        sx_reg <= sx_next;
        tx_reg <= tx_next;
        bf_reg <= bf_next;
        sf_reg <= sf_next;
        tf_reg <= tf_next;
        trial_reg <= trial_next;
        fu_reg <= fu_next;
        xm_reg <= xm_next;
        t3_reg <= t3_next;
        tol1_reg <= tol1_next;
        tol2_reg <= tol2_next;
        ta_reg <= ta_next;
        tb_reg <= tb_next;
        tc_reg <= tc_next;
        dw_reg <= dw_next;
        dv_reg <= dv_next;
        p_reg <= p_next;
        q_reg <= q_next;
        pt_reg <= pt_next;
        st_reg <= st_next;
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        mneg_reg <= mneg_next;
        macc_reg <= macc_next;
        mcnt_reg <= mcnt_next;
        mres_reg <= mres_next;
        drem_reg <= drem_next;
        dlo_reg <= dlo_next;
        dquo_reg <= dquo_next;
        dd_reg <= dd_next;
        dneg_reg <= dneg_next;
        dcnt_reg <= dcnt_next;
        dres_reg <= dres_next;
    end

    always_comb
    begin
        logic mul_go;
        bms_pkg::q_t mul_a, mul_b;
        logic div_go;
        logic [63:0] div_hi, div_lo, div_d;
        logic div_neg;
        logic [31:0] a_sel, b_sel;
        logic [63:0] pp;
        logic [127:0] ppx;
        logic [63:0] rem2, ua, mm;
        logic carry, qbit, golden;
        bms_pkg::q_t u, pv;

        mul_go = 1'b0;
        mul_a = '0;
        mul_b = '0;
        div_go = 1'b0;
        div_hi = '0;
        div_lo = '0;
        div_d = '0;
        div_neg = 1'b0;
        a_sel = '0;
        b_sel = '0;
        pp = '0;
        ppx = '0;
        rem2 = '0;
        ua = '0;
        mm = '0;
        carry = 1'b0;
        qbit = 1'b0;
        golden = 1'b0;
        u = '0;
        pv = '0;

        state_next = state_reg;
        ret_next = ret_reg;
        phase_next = phase_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        step_next = step_reg;
        prev_next = prev_reg;
        bx_next = bx_reg;
        sx_next = sx_reg;
        tx_next = tx_reg;
        bf_next = bf_reg;
        sf_next = sf_reg;
        tf_next = tf_reg;
        trial_next = trial_reg;
        fu_next = fu_reg;
        xm_next = xm_reg;
        t3_next = t3_reg;
        tol1_next = tol1_reg;
        tol2_next = tol2_reg;
        ta_next = ta_reg;
        tb_next = tb_reg;
        tc_next = tc_reg;
        dw_next = dw_reg;
        dv_next = dv_reg;
        p_next = p_reg;
        q_next = q_reg;
        pt_next = pt_reg;
        st_next = st_reg;
        ma_next = ma_reg;
        mb_next = mb_reg;
        mneg_next = mneg_reg;
        macc_next = macc_reg;
        mcnt_next = mcnt_reg;
        mres_next = mres_reg;
        drem_next = drem_reg;
        dlo_next = dlo_reg;
        dquo_next = dquo_reg;
        dd_next = dd_reg;
        dneg_next = dneg_reg;
        dcnt_next = dcnt_reg;
        dres_next = dres_reg;

        unique case (state_reg)
            bms_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == bms_pkg::CMD_START)
                    begin
                        lo_next = lower_end;
                        hi_next = upper_end;
                        step_next = '0;
                        prev_next = '0;
                        phase_next = bms_pkg::PH_FIRST;
                        mul_go = 1'b1;
                        mul_a = bms_pkg::GOLD;
                        mul_b = bms_pkg::sat_sub(upper_end, lower_end);
                        ret_next = bms_pkg::S_ST1;
                    end
                    else if (phase_reg == bms_pkg::PH_FIRST)
                    begin
                        bf_next = func_value;
                        sf_next = func_value;
                        tf_next = func_value;
                        state_next = bms_pkg::S_A0;
                    end
                    else if (phase_reg == bms_pkg::PH_TRIAL)
                    begin
                        fu_next = func_value;
                        state_next = bms_pkg::S_T0;
                    end
                    else
                    begin
                        pt_next = '0;
                        st_next = bms_pkg::ST_IGNORED;
                        state_next = bms_pkg::S_OUT;
                    end
                end
            end
            bms_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = bms_pkg::S_IDLE;
                end
            end
            bms_pkg::S_ST1:
            begin
                u = bms_pkg::sat_add(lo_reg, mres_reg);
                bx_next = u;
                sx_next = u;
                tx_next = u;
                trial_next = u;
                pt_next = u;
                st_next = bms_pkg::ST_EVAL;
                state_next = bms_pkg::S_OUT;
            end
            bms_pkg::S_T0:
            begin
                if (fu_reg > bf_reg)
                begin
                    if (trial_reg < bx_reg)
                    begin
                        lo_next = trial_reg;
                    end
                    else
                    begin
                        hi_next = trial_reg;
                    end
                    if (fu_reg <= sf_reg || sx_reg == bx_reg)
                    begin
                        tx_next = sx_reg;
                        tf_next = sf_reg;
                        sx_next = trial_reg;
                        sf_next = fu_reg;
                    end
                    else if (fu_reg <= tf_reg || tx_reg == bx_reg || tx_reg == sx_reg)
                    begin
                        tx_next = trial_reg;
                        tf_next = fu_reg;
                    end
                end
                else
                begin
                    if (trial_reg >= bx_reg)
                    begin
                        lo_next = bx_reg;
                    end
                    else
                    begin
                        hi_next = bx_reg;
                    end
                    tx_next = sx_reg;
                    tf_next = sf_reg;
                    sx_next = bx_reg;
                    sf_next = bf_reg;
                    bx_next = trial_reg;
                    bf_next = fu_reg;
                end
                state_next = bms_pkg::S_A0;
            end
            bms_pkg::S_A0:
            begin
                xm_next = bms_pkg::midpoint(lo_reg, hi_reg);
                mul_go = 1'b1;
                mul_a = {1'b0, tolerance_reg};
                mul_b = bms_pkg::RECIP3;
                ret_next = bms_pkg::S_A1;
            end
            bms_pkg::S_A1:
            begin
                // tolerance / 3 is the high word of the raw product
                t3_next = macc_reg[127:64];
                mul_go = 1'b1;
                mul_a = {1'b0, rel_eps_reg};
                mul_b = bms_pkg::sat_abs(bx_reg);
                ret_next = bms_pkg::S_A2;
            end
            bms_pkg::S_A2:
            begin
                tol1_next = bms_pkg::sat_add(mres_reg, t3_reg);
                state_next = bms_pkg::S_A3;
            end
            bms_pkg::S_A3:
            begin
                tol2_next = bms_pkg::sat_add(tol1_reg, tol1_reg);
                ta_next = bms_pkg::sat_sub(hi_reg, lo_reg);
                tb_next = bms_pkg::sat_sub(bx_reg, xm_reg);
                state_next = bms_pkg::S_A4;
            end
            bms_pkg::S_A4:
            begin
                ta_next = bms_pkg::sat_sub(tol2_reg, bms_pkg::half_tz(ta_reg));
                tb_next = bms_pkg::sat_abs(tb_reg);
                state_next = bms_pkg::S_A5;
            end
            bms_pkg::S_A5:
            begin
                if (tb_reg <= ta_reg)
                begin
                    phase_next = bms_pkg::PH_IDLE;
                    pt_next = bx_reg;
                    st_next = bms_pkg::ST_MINIMUM;
                    state_next = bms_pkg::S_OUT;
                end
                else if (bms_pkg::sat_abs(prev_reg) > tol1_reg)
                begin
                    state_next = bms_pkg::S_P0;
                end
                else
                begin
                    state_next = bms_pkg::S_G0;
                end
            end
            bms_pkg::S_P0:
            begin
                dw_next = bms_pkg::sat_sub(bx_reg, sx_reg);
                dv_next = bms_pkg::sat_sub(bx_reg, tx_reg);
                tb_next = bms_pkg::sat_sub(bf_reg, sf_reg);
                mul_go = 1'b1;
                mul_a = bms_pkg::sat_sub(bx_reg, sx_reg);
                mul_b = bms_pkg::sat_sub(bf_reg, tf_reg);
                ret_next = bms_pkg::S_P1;
            end
            bms_pkg::S_P1:
            begin
                ta_next = mres_reg;
                mul_go = 1'b1;
                mul_a = dv_reg;
                mul_b = tb_reg;
                ret_next = bms_pkg::S_P2;
            end
            bms_pkg::S_P2:
            begin
                q_next = mres_reg;
                mul_go = 1'b1;
                mul_a = dv_reg;
                mul_b = mres_reg;
                ret_next = bms_pkg::S_P3;
            end
            bms_pkg::S_P3:
            begin
                p_next = mres_reg;
                mul_go = 1'b1;
                mul_a = dw_reg;
                mul_b = ta_reg;
                ret_next = bms_pkg::S_P4;
            end
            bms_pkg::S_P4:
            begin
                p_next = bms_pkg::sat_sub(p_reg, mres_reg);
                ta_next = bms_pkg::sat_sub(q_reg, ta_reg);
                state_next = bms_pkg::S_P5;
            end
            bms_pkg::S_P5:
            begin
                q_next = bms_pkg::sat_add(ta_reg, ta_reg);
                state_next = bms_pkg::S_P6;
            end
            bms_pkg::S_P6:
            begin
                if (q_reg > 0)
                begin
                    p_next = bms_pkg::sat_neg(p_reg);
                end
                q_next = bms_pkg::sat_abs(q_reg);
                prev_next = step_reg;
                mul_go = 1'b1;
                mul_a = bms_pkg::sat_abs(q_reg);
                mul_b = prev_reg;
                ret_next = bms_pkg::S_P7;
            end
            bms_pkg::S_P7:
            begin
                ta_next = bms_pkg::sat_abs(bms_pkg::half_tz(mres_reg));
                tb_next = bms_pkg::sat_abs(p_reg);
                mul_go = 1'b1;
                mul_a = q_reg;
                mul_b = bms_pkg::sat_sub(lo_reg, bx_reg);
                ret_next = bms_pkg::S_P8;
            end
            bms_pkg::S_P8:
            begin
                tc_next = mres_reg;
                mul_go = 1'b1;
                mul_a = q_reg;
                mul_b = bms_pkg::sat_sub(hi_reg, bx_reg);
                ret_next = bms_pkg::S_P9;
            end
            bms_pkg::S_P9:
            begin
                golden = (tb_reg >= ta_reg) || (p_reg <= tc_reg) || (p_reg >= mres_reg);
                ua = bms_pkg::mag(p_reg);
                if (golden)
                begin
                    state_next = bms_pkg::S_G0;
                end
                else if (q_reg == 0)
                begin
                    if (p_reg == 0)
                    begin
                        dres_next = '0;
                    end
                    else
                    begin
                        dres_next = p_reg[63] ? bms_pkg::Q_MIN : bms_pkg::Q_MAX;
                    end
                    state_next = bms_pkg::S_P10;
                end
                else if ((ua >> (64 - FB)) >= q_reg)
                begin
                    dres_next = bms_pkg::pack(p_reg[63] ^ q_reg[63], '1);
                    state_next = bms_pkg::S_P10;
                end
                else
                begin
                    div_go = 1'b1;
                    div_hi = ua >> (64 - FB);
                    div_lo = ua << FB;
                    div_d = q_reg;
                    div_neg = p_reg[63] ^ q_reg[63];
                    ret_next = bms_pkg::S_P10;
                end
            end
            bms_pkg::S_P10:
            begin
                step_next = dres_reg;
                tc_next = bms_pkg::sat_add(bx_reg, dres_reg);
                state_next = bms_pkg::S_P11;
            end
            bms_pkg::S_P11:
            begin
                if (bms_pkg::sat_sub(tc_reg, lo_reg) < tol2_reg
                    || bms_pkg::sat_sub(hi_reg, tc_reg) < tol2_reg)
                begin
                    step_next = (bms_pkg::sat_sub(xm_reg, bx_reg) >= 0) ? tol1_reg
                                                                        : -tol1_reg;
                end
                state_next = bms_pkg::S_F0;
            end
            bms_pkg::S_G0:
            begin
                pv = (bx_reg >= xm_reg) ? bms_pkg::sat_sub(lo_reg, bx_reg)
                                        : bms_pkg::sat_sub(hi_reg, bx_reg);
                prev_next = pv;
                mul_go = 1'b1;
                mul_a = bms_pkg::GOLD;
                mul_b = pv;
                ret_next = bms_pkg::S_G1;
            end
            bms_pkg::S_G1:
            begin
                step_next = mres_reg;
                state_next = bms_pkg::S_F0;
            end
            bms_pkg::S_F0:
            begin
                if (bms_pkg::sat_abs(step_reg) >= tol1_reg)
                begin
                    u = bms_pkg::sat_add(bx_reg, step_reg);
                end
                else
                begin
                    u = bms_pkg::sat_add(bx_reg, step_reg[63] ? -tol1_reg : tol1_reg);
                end
                trial_next = u;
                phase_next = bms_pkg::PH_TRIAL;
                pt_next = u;
                st_next = bms_pkg::ST_EVAL;
                state_next = bms_pkg::S_OUT;
            end
            bms_pkg::S_MUL:
            begin
                a_sel = mcnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
                b_sel = mcnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
                pp = a_sel * b_sel;
                ppx = {64'd0, pp};
                unique case (mcnt_reg)
                    2'd0:    macc_next = macc_reg + ppx;
                    2'd1:    macc_next = macc_reg + (ppx << 32);
                    2'd2:    macc_next = macc_reg + (ppx << 32);
                    default: macc_next = macc_reg + (ppx << 64);
                endcase
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    state_next = bms_pkg::S_MULF;
                end
            end
            bms_pkg::S_MULF:
            begin
                mm = macc_reg[FB+63:FB];
                if (|macc_reg[127:64+FB])
                begin
                    mm = '1;
                end
                mres_next = bms_pkg::pack(mneg_reg, mm);
                state_next = ret_reg;
            end
            bms_pkg::S_DIV:
            begin
                carry = drem_reg[63];
                rem2 = {drem_reg[62:0], dlo_reg[63]};
                qbit = carry || (rem2 >= dd_reg);
                drem_next = qbit ? (rem2 - dd_reg) : rem2;
                dlo_next = {dlo_reg[62:0], 1'b0};
                dquo_next = {dquo_reg[62:0], qbit};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                begin
                    state_next = bms_pkg::S_DIVF;
                end
            end
            bms_pkg::S_DIVF:
            begin
                dres_next = bms_pkg::pack(dneg_reg, dquo_reg);
                state_next = ret_reg;
            end
            default:
            begin
                state_next = bms_pkg::S_IDLE;
            end
        endcase

        if (mul_go)
        begin
            ma_next = bms_pkg::mag(mul_a);
            mb_next = bms_pkg::mag(mul_b);
            mneg_next = mul_a[63] ^ mul_b[63];
            macc_next = '0;
            mcnt_next = '0;
            state_next = bms_pkg::S_MUL;
        end
        if (div_go)
        begin
            drem_next = div_hi;
            dlo_next = div_lo;
            dd_next = div_d;
            dneg_next = div_neg;
            dquo_next = '0;
            dcnt_next = '0;
            state_next = bms_pkg::S_DIV;
        end
    end

    a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    a_min_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == bms_pkg::ST_MINIMUM) |-> phase_reg == bms_pkg::PH_IDLE)
        else $error("minimum reported with search still active");

    a_eval_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == bms_pkg::ST_EVAL) |-> phase_reg != bms_pkg::PH_IDLE)
        else $error("trial point requested while idle");

    a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bms_pkg::S_MUL && mcnt_reg != 2'd3) |=> state_reg == bms_pkg::S_MUL)
        else $error("multiplier pass cut short");

    a_tol_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bms_pkg::S_F0) |-> !tol1_reg[63])
        else $error("negative tol1");

endmodule

/* tb/tb_brent_minimizer_step.sv */
// Testbench for brent_minimizer_step: drives start and value requests, predicts
// each response with a fixed-point model of the search, and checks it field by field.
// Depends on bms_pkg and the brent_minimizer_step RTL.
`timescale 1ns / 1ps

module tb_brent_minimizer_step;

    typedef struct packed {
        logic [63:0] point;
        logic [1:0]  status;
    } resp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [63:0] lower_end;
    logic [63:0] upper_end;
    logic [63:0] func_value;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] point;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [63:0] cfg_data;

    brent_minimizer_step u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .lower_end(lower_end), .upper_end(upper_end), .func_value(func_value),
        .out_valid(out_valid), .out_ready(out_ready), .point(point), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // search model state
    bms_pkg::q_t     m_tol, m_eps;
    bms_pkg::q_t     m_lo, m_hi, m_step, m_pstep;
    bms_pkg::q_t     m_bx, m_sx, m_tx, m_bf, m_sf, m_tf, m_trial;
    bms_pkg::phase_t m_phase;

    resp_t  expected_resp[$];
    int     errors;
    int     n_sent;
    int     n_resp;
    int     n_min;
    int     n_ign;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off;
    int     quiet_cycles;

    function automatic bms_pkg::q_t fx_mul(bms_pkg::q_t a, bms_pkg::q_t b);
        logic         neg;
        logic [127:0] p;
        neg = a[63] ^ b[63];
        p = {64'd0, bms_pkg::mag(a)} * {64'd0, bms_pkg::mag(b)};
        if (p[127:64+bms_pkg::FRAC_BITS] != 0)
            return bms_pkg::pack(neg, '1);
        return bms_pkg::pack(neg, p[63+bms_pkg::FRAC_BITS:bms_pkg::FRAC_BITS]);
    endfunction

    function automatic bms_pkg::q_t fx_div(bms_pkg::q_t a, bms_pkg::q_t b);
        logic         neg;
        logic [127:0] n;
        logic [127:0] qq;
        neg = a[63] ^ b[63];
        if (b == 0)
            return (a == 0) ? bms_pkg::q_t'(0) : (a[63] ? bms_pkg::Q_MIN : bms_pkg::Q_MAX);
        n = {64'd0, bms_pkg::mag(a)} << bms_pkg::FRAC_BITS;
        qq = n / {64'd0, bms_pkg::mag(b)};
        if (qq[127:64] != 0)
            return bms_pkg::pack(neg, '1);
        return bms_pkg::pack(neg, qq[63:0]);
    endfunction

    function automatic bms_pkg::q_t sdiv2(bms_pkg::q_t a);
        return a / 2;
    endfunction

    function automatic resp_t search_advance();
        bms_pkg::q_t xm, tol1, tol2, u, dw, dv, r, q, p, qr;
        logic        golden;
        resp_t       o;
        golden = 1'b1;
        xm = m_lo / 2 + m_hi / 2 + (m_lo % 2 + m_hi % 2) / 2;
        tol1 = bms_pkg::sat_add(fx_mul(m_eps, bms_pkg::sat_abs(m_bx)), m_tol / 3);
        tol2 = bms_pkg::sat_add(tol1, tol1);
        if (bms_pkg::sat_abs(bms_pkg::sat_sub(m_bx, xm))
            <= bms_pkg::sat_sub(tol2, sdiv2(bms_pkg::sat_sub(m_hi, m_lo))))
        begin
            m_phase = bms_pkg::PH_IDLE;
            o.point = m_bx;
            o.status = bms_pkg::ST_MINIMUM;
            return o;
        end
        if (bms_pkg::sat_abs(m_pstep) > tol1)
        begin
            dw = bms_pkg::sat_sub(m_bx, m_sx);
            dv = bms_pkg::sat_sub(m_bx, m_tx);
            r = fx_mul(dw, bms_pkg::sat_sub(m_bf, m_tf));
            q = fx_mul(dv, bms_pkg::sat_sub(m_bf, m_sf));
            p = bms_pkg::sat_sub(fx_mul(dv, q), fx_mul(dw, r));
            qr = bms_pkg::sat_sub(q, r);
            q = bms_pkg::sat_add(qr, qr);
            if (q > 0)
                p = bms_pkg::sat_neg(p);
            q = bms_pkg::sat_abs(q);
            r = m_pstep;
            m_pstep = m_step;
            if (!(bms_pkg::sat_abs(p) >= bms_pkg::sat_abs(sdiv2(fx_mul(q, r)))
                  || p <= fx_mul(q, bms_pkg::sat_sub(m_lo, m_bx))
                  || p >= fx_mul(q, bms_pkg::sat_sub(m_hi, m_bx))))
            begin
                golden = 1'b0;
                m_step = fx_div(p, q);
                u = bms_pkg::sat_add(m_bx, m_step);
                if (bms_pkg::sat_sub(u, m_lo) < tol2 || bms_pkg::sat_sub(m_hi, u) < tol2)
                    m_step = (bms_pkg::sat_sub(xm, m_bx) >= 0) ? tol1 : -tol1;
            end
        end
        if (golden)
        begin
            m_pstep = (m_bx >= xm) ? bms_pkg::sat_sub(m_lo, m_bx)
                                   : bms_pkg::sat_sub(m_hi, m_bx);
            m_step = fx_mul(bms_pkg::GOLD, m_pstep);
        end
        if (bms_pkg::sat_abs(m_step) >= tol1)
            u = bms_pkg::sat_add(m_bx, m_step);
        else
            u = bms_pkg::sat_add(m_bx, (m_step >= 0) ? tol1 : -tol1);
        m_trial = u;
        m_phase = bms_pkg::PH_TRIAL;
        o.point = u;
        o.status = bms_pkg::ST_EVAL;
        return o;
    endfunction

    function automatic void take_value(bms_pkg::q_t fu);
        bms_pkg::q_t u;
        u = m_trial;
        if (fu > m_bf)
        begin
            if (u < m_bx)
                m_lo = u;
            else
                m_hi = u;
            if (fu <= m_sf || m_sx == m_bx)
            begin
                m_tx = m_sx;
                m_tf = m_sf;
                m_sx = u;
                m_sf = fu;
            end
            else if (fu <= m_tf || m_tx == m_bx || m_tx == m_sx)
            begin
                m_tx = u;
                m_tf = fu;
            end
            return;
        end
        if (u >= m_bx)
            m_lo = m_bx;
        else
            m_hi = m_bx;
        m_tx = m_sx;
        m_tf = m_sf;
        m_sx = m_bx;
        m_sf = m_bf;
        m_bx = u;
        m_bf = fu;
    endfunction

    function automatic resp_t predict_response(logic c, bms_pkg::q_t lo, bms_pkg::q_t hi,
                                               bms_pkg::q_t fv);
        resp_t o;
        if (c == bms_pkg::CMD_START)
        begin
            m_lo = lo;
            m_hi = hi;
            m_bx = bms_pkg::sat_add(lo, fx_mul(bms_pkg::GOLD, bms_pkg::sat_sub(hi, lo)));
            m_sx = m_bx;
            m_tx = m_bx;
            m_trial = m_bx;
            m_step = 0;
            m_pstep = 0;
            m_phase = bms_pkg::PH_FIRST;
            o.point = m_bx;
            o.status = bms_pkg::ST_EVAL;
            return o;
        end
        if (m_phase == bms_pkg::PH_FIRST)
        begin
            m_bf = fv;
            m_sf = fv;
            m_tf = fv;
            return search_advance();
        end
        if (m_phase == bms_pkg::PH_TRIAL)
        begin
            take_value(fv);
            return search_advance();
        end
        o.point = '0;
        o.status = bms_pkg::ST_IGNORED;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %h expected %h (response %0d)", what, got, want, n_resp);
    endtask

    // valid stays up at the accepting edge; the next call or drain() decides
    task automatic send_request(input logic c, input bms_pkg::q_t lo, input bms_pkg::q_t hi,
                                input bms_pkg::q_t fv);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        lower_end <= lo;
        upper_end <= hi;
        func_value <= fv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_resp.push_back(predict_response(c, lo, hi, fv));
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_resp.size() != 0)
            @(posedge clk);
        repeat (250)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == bms_pkg::REG_TOLERANCE)
            m_tol = bms_pkg::q_t'({1'b0, val[62:0]});
        else
            m_eps = bms_pkg::q_t'({1'b0, val[62:0]});
        @(posedge clk);
    endtask

    // objective by kind: (x - c) squared, |x - c|, (x - c) squared plus a linear term, or random
    function automatic bms_pkg::q_t objective(bms_pkg::q_t x, bms_pkg::q_t c, int kind);
        bms_pkg::q_t d;
        d = bms_pkg::sat_sub(x, c);
        case (kind)
            0: return fx_mul(d, d);
            1: return bms_pkg::sat_abs(d);
            2: return bms_pkg::sat_add(fx_mul(d, d),
                                       fx_mul(d, 64'sd1 << bms_pkg::FRAC_BITS - 2));
            default: return bms_pkg::q_t'({$urandom, $urandom});
        endcase
    endfunction

    task automatic run_search(input bms_pkg::q_t lo, input bms_pkg::q_t hi, input int kind,
                              input int max_steps);
        bms_pkg::q_t c;
        int k;
        c = bms_pkg::sat_add(lo,
                fx_mul(bms_pkg::q_t'($urandom_range(65535)) <<< (bms_pkg::FRAC_BITS - 16),
                       bms_pkg::sat_sub(hi, lo)));
        send_request(bms_pkg::CMD_START, lo, hi, bms_pkg::q_t'({$urandom, $urandom}));
        for (k = 0; k < max_steps && m_phase != bms_pkg::PH_IDLE; k++)
            send_request(bms_pkg::CMD_VALUE, bms_pkg::q_t'({$urandom, $urandom}),
                         bms_pkg::q_t'({$urandom, $urandom}), objective(m_trial, c, kind));
    endtask

    function automatic bms_pkg::q_t rand_q();
        case ($urandom_range(5))
            0: return bms_pkg::Q_MAX;
            1: return bms_pkg::Q_MIN;
            2: return bms_pkg::q_t'({$urandom, $urandom});
            default: return bms_pkg::q_t'($signed($urandom_range(200000)) - 100000)
                            <<< (bms_pkg::FRAC_BITS - 8);
        endcase
    endfunction

    task automatic test_directed();
        send_request(bms_pkg::CMD_VALUE, bms_pkg::Q_MAX, bms_pkg::Q_MIN, bms_pkg::Q_MAX);
        send_request(bms_pkg::CMD_VALUE, bms_pkg::Q_MIN, bms_pkg::Q_MAX, bms_pkg::Q_MIN);
        send_request(bms_pkg::CMD_START, bms_pkg::Q_MIN, bms_pkg::Q_MAX, 0);
        send_request(bms_pkg::CMD_VALUE, bms_pkg::Q_MAX, bms_pkg::Q_MIN, bms_pkg::Q_MIN);
        send_request(bms_pkg::CMD_START, bms_pkg::Q_MAX, bms_pkg::Q_MIN, 0);
        send_request(bms_pkg::CMD_VALUE, '0, '0, bms_pkg::Q_MAX);
        send_request(bms_pkg::CMD_VALUE, '0, '0, '1);
        send_request(bms_pkg::CMD_START, 64'sd5, 64'sd5, 0);
        send_request(bms_pkg::CMD_VALUE, '0, '0, 0);
        send_request(bms_pkg::CMD_VALUE, '0, '0, 0);
        send_request(bms_pkg::CMD_START, -(64'sd1 <<< bms_pkg::FRAC_BITS),
                     64'sd3 <<< bms_pkg::FRAC_BITS, 0);
        send_request(bms_pkg::CMD_START, -(64'sd1 <<< bms_pkg::FRAC_BITS),
                     64'sd3 <<< bms_pkg::FRAC_BITS, 0);
        send_request(bms_pkg::CMD_VALUE, '0, '0, 64'sd1 <<< bms_pkg::FRAC_BITS);
        send_request(bms_pkg::CMD_VALUE, '0, '0, 64'sd2 <<< bms_pkg::FRAC_BITS);
        send_request(bms_pkg::CMD_VALUE, '0, '0, 0);
        send_request(bms_pkg::CMD_VALUE, '0, '0, -(64'sd1 <<< bms_pkg::FRAC_BITS));
        send_request(bms_pkg::CMD_START, 0, 64'sd1 <<< bms_pkg::FRAC_BITS, 0);
        run_search(0, 64'sd1 <<< bms_pkg::FRAC_BITS, 0, 60);
        drain();
    endtask

    task automatic test_random(input int count, input logic [63:0] tol, input logic [63:0] eps);
        int          k;
        int          target;
        bms_pkg::q_t lo, hi;
        write_reg(bms_pkg::REG_TOLERANCE, tol);
        write_reg(bms_pkg::REG_REL_EPS, eps);
        target = n_sent + count;
        while (n_sent < target)
        begin
            k = $urandom_range(9);
            if (k == 0)
                send_request($urandom_range(1), rand_q(), rand_q(), rand_q());
            else
            begin
                lo = rand_q();
                hi = (k == 1) ? rand_q() : bms_pkg::sat_add(lo, bms_pkg::sat_abs(rand_q()));
                run_search(lo, hi, $urandom_range(3), $urandom_range(1, 30));
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        int k;
        hold_off = 400;
        for (k = 0; k < 6; k++)
            send_request(bms_pkg::CMD_START, bms_pkg::q_t'(k) <<< bms_pkg::FRAC_BITS,
                         bms_pkg::q_t'(k + 4) <<< bms_pkg::FRAC_BITS, 0);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        resp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_resp++;
            if (expected_resp.size() == 0)
                report_mismatch("unexpected response", point, 64'd0);
            else
            begin
                want = expected_resp.pop_front();
                if (point !== want.point)
                    report_mismatch("point", point, want.point);
                if (status !== want.status)
                    report_mismatch("status", {62'd0, status}, {62'd0, want.status});
                if (status === bms_pkg::ST_MINIMUM)
                    n_min++;
                if (status === bms_pkg::ST_IGNORED)
                    n_ign++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = bms_pkg::CMD_START;
        lower_end = '0;
        upper_end = '0;
        func_value = '0;
        cfg_valid = 1'b0;
        cfg_index = bms_pkg::REG_TOLERANCE;
        cfg_data = '0;
        errors = 0;
        n_sent = 0;
        n_resp = 0;
        n_min = 0;
        n_ign = 0;
        hold_off = 0;
        quiet_cycles = 0;
        send_idle_pct = 17;
        recv_idle_pct = 47;
        m_tol = bms_pkg::q_t'({1'b0, bms_pkg::TOL_RESET});
        m_eps = bms_pkg::q_t'({1'b0, bms_pkg::REL_EPS_RESET});
        m_lo = 0; m_hi = 0; m_step = 0; m_pstep = 0;
        m_bx = 0; m_sx = 0; m_tx = 0; m_bf = 0; m_sf = 0; m_tf = 0; m_trial = 0;
        m_phase = bms_pkg::PH_IDLE;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(260, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
        test_backpressure();
        send_idle_pct = 47;
        recv_idle_pct = 17;
        test_random(260, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250, {1'b1, 63'd281474976}, 64'd4194304);

        $display("covered %0d requests, %0d responses: %0d minima, %0d ignored values",
                 n_sent, n_resp, n_min, n_ign);
        $display("register extremes, reversed/empty intervals, restarts and long stalls");
        if (errors == 0 && expected_resp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bms_pkg.sv
rtl/brent_minimizer_step.sv
tb/tb_brent_minimizer_step.sv
